// ===== sv/pcsm_pkg.sv =====
// Shared types and constants of the pairing channel search monitor.
// No dependencies; imported by every module of the block.
package pcsm_pkg;

    // Frame and event codes of an input beat
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_STATUS  = 2'd1;
    localparam logic [1:0] OP_PAIRING = 2'd2;
    localparam logic [1:0] OP_OTHER   = 2'd3;

    // Pairing state codes; code 3 is unused and behaves like ST_REQUEST
    localparam logic [1:0] ST_REQUEST   = 2'd0;
    localparam logic [1:0] ST_REQUESTED = 2'd1;
    localparam logic [1:0] ST_PAIRED    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOP_CHANNEL  = 2'd0;
    localparam logic [1:0] CFG_DWELL        = 2'd1;
    localparam logic [1:0] CFG_SILENCE      = 2'd2;
    localparam logic [1:0] CFG_READING_AGE  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [3:0]  TOP_CHANNEL_RST = 4'd11;
    localparam logic [15:0] DWELL_RST       = 16'd500;
    localparam logic [31:0] SILENCE_RST     = 32'd60000;
    localparam logic [31:0] READING_AGE_RST = 32'd60000;

    // Freezing point of water in 1/16 degree F
    localparam logic signed [16:0] FREEZE_F16 = 17'sd512;

    // ceil(2^21 / 9): exact quotient by 9 for magnitudes below 2^21
    localparam int unsigned        RECIP9_SHIFT = 21;
    localparam logic [17:0]        RECIP9       = 18'd233017;

    typedef logic signed [15:0] t_temp;

endpackage

// ===== sv/pcsm_f2c.sv =====
// Fahrenheit to Celsius conversion, both in 1/16 degree, truncated toward zero.
// Depends on pcsm_pkg (constants, t_temp).
module pcsm_f2c (
    input  pcsm_pkg::t_temp i_temp_f,
    output pcsm_pkg::t_temp o_temp_c
);
    import pcsm_pkg::*;

    logic signed [16:0] diff;
    logic signed [18:0] times5;
    logic               neg;
    logic        [17:0] mag;
    logic        [35:0] prod;
    logic        [14:0] quot;

    // (F - 32) * 5 as a signed value, then magnitude for the divide
    assign diff   = 17'(signed'(i_temp_f)) - FREEZE_F16;
    assign times5 = 19'(diff) * 19'sd5;
    assign neg    = times5[18];
    assign mag    = neg ? 18'(-times5) : 18'(times5);

    // Divide by 9 through the reciprocal; magnitude stays below 2^18
    assign prod = 36'(mag) * 36'(RECIP9);
    assign quot = prod[RECIP9_SHIFT +: 15];

    // Restore the sign; truncation toward zero falls out of the magnitude form
    assign o_temp_c = neg ? -t_temp'({1'b0, quot}) : t_temp'({1'b0, quot});

endmodule

// ===== sv/pairing_channel_search_monitor.sv =====
// Top level of the pairing channel search monitor: input register, state update,
// result register. Depends on pcsm_pkg and pcsm_f2c.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+------------------------------------------
//   input   | i_in_valid  | o_in_ready   | i_op i_now_ms i_sender_board
//           |             |              | i_reply_channel i_water_temp_f
//   result  | o_out_valid | i_out_ready  | o_send_request o_tx_channel o_paired
//           |             |              | o_temp_ok o_temp_c
//   config  | i_cfg_valid | o_cfg_ready  | i_cfg_index i_cfg_data
//
// One beat per cycle in each direction while the result side is not stalled; a result
// beat passes the input register and then the result register.
// The state update and the Celsius multiply sit between the input and result registers.
// Synchronous active-low reset clears control state and loads register defaults.
// A stalled result holds the result register; the input register still frees up
// while the result register is empty or being taken. The config port is always ready.
module pairing_channel_search_monitor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input beats
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_now_ms,
    input  logic [7:0]           i_sender_board,
    input  logic [7:0]           i_reply_channel,
    input  pcsm_pkg::t_temp      i_water_temp_f,
    // result beats
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_send_request,
    output logic [7:0]           o_tx_channel,
    output logic                 o_paired,
    output logic                 o_temp_ok,
    output pcsm_pkg::t_temp      o_temp_c,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import pcsm_pkg::*;

    // configuration registers
    logic [3:0]  r_top_channel;
    logic [15:0] r_dwell;
    logic [31:0] r_silence;
    logic [31:0] r_reading_age;

    // input register
    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [31:0] r_s1_now;
    logic [7:0]  r_s1_board;
    logic [7:0]  r_s1_rchan;
    t_temp       r_s1_temp;

    // block state
    logic [1:0]  r_pair_state, n_pair_state;
    logic [7:0]  r_search_ch,  n_search_ch;
    logic [31:0] r_req_time,   n_req_time;
    logic [31:0] r_last_heard, n_last_heard;
    logic        r_have_rd,    n_have_rd;
    t_temp       r_temp_c,     n_temp_c;

    // result register
    logic        r_out_valid;
    logic        r_send, n_send;
    logic [7:0]  r_txc,  n_txc;
    logic        r_paired, n_paired;
    logic        r_ok,   n_ok;
    t_temp       r_tc,   n_tc;

    logic        s1_go;
    logic        heard;
    logic [31:0] req_age;
    logic [31:0] heard_age;
    t_temp       conv_c;

    // pipeline control
    assign s1_go       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_go;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_channel <= TOP_CHANNEL_RST;
            r_dwell       <= DWELL_RST;
            r_silence     <= SILENCE_RST;
            r_reading_age <= READING_AGE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOP_CHANNEL: r_top_channel <= i_cfg_data[3:0];
                CFG_DWELL:       r_dwell       <= i_cfg_data[15:0];
                CFG_SILENCE:     r_silence     <= i_cfg_data;
                CFG_READING_AGE: r_reading_age <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_op    <= i_op;
            r_s1_now   <= i_now_ms;
            r_s1_board <= i_sender_board;
            r_s1_rchan <= i_reply_channel;
            r_s1_temp  <= i_water_temp_f;
        end
    end

    // Celsius of the beat's temperature; stored in Celsius form
    pcsm_f2c u_f2c (
        .i_temp_f (r_s1_temp),
        .o_temp_c (conv_c)
    );

    assign req_age   = r_s1_now - r_req_time;
    assign heard_age = r_s1_now - r_last_heard;

    // state update for the beat in the input register
    always_comb begin
        n_pair_state = r_pair_state;
        n_search_ch  = r_search_ch;
        n_req_time   = r_req_time;
        n_last_heard = r_last_heard;
        n_have_rd    = r_have_rd;
        n_temp_c     = r_temp_c;
        n_send       = 1'b0;
        n_txc        = 8'd0;
        heard        = 1'b0;
        case (r_s1_op)
            OP_TICK: begin
                case (r_pair_state)
                    ST_REQUESTED: begin
                        if (req_age > 32'(r_dwell)) begin
                            // hop down, wrap from channel 1 or 0 to the top
                            if (r_search_ch <= 8'd1) begin
                                n_search_ch = 8'(r_top_channel);
                            end else begin
                                n_search_ch = r_search_ch - 8'd1;
                            end
                            n_pair_state = ST_REQUEST;
                        end
                    end
                    ST_PAIRED: begin
                        // zero timestamp counts as silence
                        if (r_last_heard == 32'd0 || heard_age > r_silence) begin
                            n_pair_state = ST_REQUEST;
                        end
                    end
                    default: begin
                        n_send       = 1'b1;
                        n_txc        = r_search_ch;
                        n_req_time   = r_s1_now;
                        n_pair_state = ST_REQUESTED;
                    end
                endcase
            end
            OP_STATUS: begin
                n_temp_c     = conv_c;
                n_last_heard = r_s1_now;
                n_have_rd    = 1'b1;
                heard        = 1'b1;
            end
            OP_PAIRING: begin
                if (r_s1_board == 8'd0) begin
                    n_search_ch  = r_s1_rchan;
                    n_pair_state = ST_PAIRED;
                    n_last_heard = r_s1_now;
                    heard        = 1'b1;
                end
            end
            default: ;
        endcase

        // freshness judged after this beat; a fresh timestamp has age zero
        n_paired = (n_pair_state == ST_PAIRED);
        n_ok     = n_have_rd && (heard || heard_age <= r_reading_age);
        n_tc     = n_ok ? n_temp_c : t_temp'(0);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_state <= ST_REQUEST;
            r_search_ch  <= 8'(TOP_CHANNEL_RST);
            r_req_time   <= 32'd0;
            r_last_heard <= 32'd0;
            r_have_rd    <= 1'b0;
        end else if (s1_go) begin
            r_pair_state <= n_pair_state;
            r_search_ch  <= n_search_ch;
            r_req_time   <= n_req_time;
            r_last_heard <= n_last_heard;
            r_have_rd    <= n_have_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_temp_c <= n_temp_c;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_send   <= n_send;
            r_txc    <= n_txc;
            r_paired <= n_paired;
            r_ok     <= n_ok;
            r_tc     <= n_tc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_request = r_send;
    assign o_tx_channel   = r_txc;
    assign o_paired       = r_paired;
    assign o_temp_ok      = r_ok;
    assign o_temp_c       = r_tc;

endmodule

// ===== sv/pcsm_checker.sv =====
// Port-level checks of the pairing channel search monitor, bound to the top level.
// Depends on pcsm_pkg (t_temp) and the top level's port names.
module pcsm_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_in_ready,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  logic            o_send_request,
    input  logic [7:0]      o_tx_channel,
    input  logic            o_paired,
    input  logic            o_temp_ok,
    input  pcsm_pkg::t_temp o_temp_c
);
    import pcsm_pkg::*;

    // no result beat right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tx_channel)
            && $stable(o_temp_c) && $stable(o_send_request))
        else $error("stalled result beat changed");

    // channel only shown with a request, and a request is never sent while paired
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_request || o_tx_channel == 8'd0)
            && !(o_send_request && o_paired))
        else $error("request strobe inconsistent");

    // stale temperature reads zero, fresh one within the converted range
    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temp_ok || o_temp_c == t_temp'(0))
            && o_temp_c >= -16'sd18488 && o_temp_c <= 16'sd17919)
        else $error("temperature out of contract");

    // with the result register empty the input side is open
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(!o_out_valid) && $past(i_rst_n) |-> o_in_ready)
        else $error("input blocked while result side idle");

endmodule

bind pairing_channel_search_monitor pcsm_checker u_pcsm_checker (.*);
